// ----- rtl/core/pure_pursuit_steering_top_assert.svh -----
// ----------------------------------------------------------------------------
// Pure pursuit steering - assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PURE_PURSUIT_STEERING_TOP_ASSERT_SVH
`define PURE_PURSUIT_STEERING_TOP_ASSERT_SVH

// Same-cycle implication
`define PPS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pure pursuit steering assertion failed");

// Next-cycle implication
`define PPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pure pursuit steering assertion failed");

`endif

// ----- rtl/core/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// pps_pkg
// Types, constants and rounding helpers of the pure pursuit steering block.
// ----------------------------------------------------------------------------
package pps_pkg;

  // CORDIC datapath widths: vector operands and angle accumulator
  localparam int CW = 52;
  localparam int AW = 20;
  localparam int CORDIC_STEPS = 16;

  // Angles in Q2.13
  localparam logic signed [17:0] PI_Q13      = 18'sd25736;
  localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;

  // Angles on the internal scale of 2^16 per radian
  localparam logic signed [AW-1:0] HALF_PI_INT = 20'sd102944;

  // Normalization threshold 2^45 and gain-compensated unit vector
  localparam logic signed [CW-1:0] NORM_LIM  = 52'sd35184372088832;
  localparam logic signed [CW-1:0] COS_START = 52'sd652032874;

  // Cosine clamp, Q1.14
  localparam logic signed [CW-1:0] COS_MAX = 52'sd16384;

  // Item kinds
  localparam logic [1:0] OP_POSE  = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Register indexes
  localparam logic REG_WHEELBASE = 1'b0;
  localparam logic REG_GAIN      = 1'b1;

  localparam logic [19:0] WHEELBASE_RST = 20'd19661;
  localparam logic [15:0] GAIN_RST      = 16'd19661;

  typedef struct packed {
    logic start;
    logic rot;
  } cordic_req_t;

  // Arctangent of 2^-i on the internal scale
  function automatic logic signed [AW-1:0] atan_entry(input logic [3:0] idx);
    logic signed [AW-1:0] v;
    case (idx)
      4'd0:    v = 20'sd51472;
      4'd1:    v = 20'sd30385;
      4'd2:    v = 20'sd16055;
      4'd3:    v = 20'sd8150;
      4'd4:    v = 20'sd4091;
      4'd5:    v = 20'sd2047;
      4'd6:    v = 20'sd1024;
      4'd7:    v = 20'sd512;
      4'd8:    v = 20'sd256;
      4'd9:    v = 20'sd128;
      4'd10:   v = 20'sd64;
      4'd11:   v = 20'sd32;
      4'd12:   v = 20'sd16;
      4'd13:   v = 20'sd8;
      4'd14:   v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

  // Internal angle to Q2.13, half away from zero
  function automatic logic signed [15:0] round3(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] m;
    if (v >= 0) m = (v + 20'sd4) >>> 3;
    else        m = -((-v + 20'sd4) >>> 3);
    return m[15:0];
  endfunction

  // Drop 16 fraction bits, half away from zero
  function automatic logic signed [CW-1:0] round16(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] m;
    if (v >= 0) m = (v + 52'sd32768) >>> 16;
    else        m = -((-v + 52'sd32768) >>> 16);
    return m;
  endfunction

  // Drop 14 fraction bits, half away from zero
  function automatic logic signed [33:0] round14(input logic signed [33:0] v);
    logic signed [33:0] m;
    if (v >= 0) m = (v + 34'sd8192) >>> 14;
    else        m = -((-v + 34'sd8192) >>> 14);
    return m;
  endfunction

endpackage

// ----- rtl/core/pure_pursuit_steering_top.sv -----
// ----------------------------------------------------------------------------
// pure_pursuit_steering_top
// Pure pursuit steering controller: pose, lookahead and tick requests.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         tuser opcode, tdata coord_x/y and quaternion
//  m_axis    out        tdata steer_angle (ticks only)
//  cfg       in         wheelbase (index 0), steer_gain (index 1)
//
//  A pose and a tick run through the shared CORDIC unit, and a tick also
//  through the bit-serial square root; each CORDIC vectoring pass first
//  doubles its operands for normalization (0 to 45 doublings).
//  A lookahead point, an unused opcode and a tick before a pose leave it idle.
//  s_axis_tready is low while a request is worked on; a finished result
//  waits in the output register, and a later tick stalls only at its end.
//  Reset restores the register defaults and clears the stored pose.
// ----------------------------------------------------------------------------
module pure_pursuit_steering_top import pps_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: coord_x[31:0], coord_y[63:32], quat_w[79:64], quat_x[95:80],
  //        quat_y[111:96], quat_z[127:112]
  input  logic [127:0] s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: steer_angle[15:0]
  output logic [15:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [19:0]  cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_YAW_S, S_YAW_W,
    S_T1, S_T2, S_T3, S_SQ_S, S_SQ_W, S_BRG_S, S_BRG_W, S_RED, S_COS_S,
    S_COS_W, S_NUM0, S_NUM1, S_ST_S, S_ST_W, S_G0, S_G1
  } state_e;

  state_e               state_q;
  logic [19:0]          wb_q;
  logic [15:0]          gain_q;
  logic signed [31:0]   car_x_q, car_y_q, tgt_x_q, tgt_y_q;
  logic signed [15:0]   heading_q;
  logic                 pose_seen_q;
  logic signed [15:0]   qw_q, qx_q, qy_q, qz_q;
  logic signed [32:0]   dx_q, dy_q;
  logic signed [CW-1:0] num_q, den_q;
  logic [63:0]          sq_q;
  logic [31:0]          dist_q;
  logic signed [15:0]   bearing_q, c_q, st_q;
  logic signed [17:0]   a_q;
  logic                 neg_q;
  logic signed [63:0]   prod_q;
  logic                 out_valid_q;
  logic [15:0]          out_data_q;

  logic signed [32:0]   mul_a, mul_b;
  logic signed [65:0]   mul_full;
  logic signed [32:0]   abs_dx, abs_dy;
  logic [31:0]          hx, hy;

  cordic_req_t          c_req;
  logic signed [CW-1:0] c_x, c_y, c_xo;
  logic signed [AW-1:0] c_z, c_zo;
  logic                 c_done;
  logic                 sq_start, sq_done;
  logic [31:0]          sq_root;

  logic signed [15:0]   ang;
  logic signed [16:0]   yaw;
  logic signed [17:0]   a_sum, a_red, a_fold;
  logic                 fold_neg;
  logic signed [CW-1:0] cos_r, cos_c;
  logic signed [33:0]   gain_r;
  logic [15:0]          steer_sat;
  logic                 in_fire;
  logic                 out_load;
  logic                 cordic_wait;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  // Load the output register once it is free
  assign out_load = (state_q == S_G1) && (!out_valid_q || m_axis_tready);

  assign cordic_wait = (state_q == S_YAW_W) || (state_q == S_BRG_W) ||
                       (state_q == S_COS_W) || (state_q == S_ST_W);

  // Half magnitudes of the car-to-target offset
  always_comb begin
    abs_dx = dx_q[32] ? -dx_q : dx_q;
    abs_dy = dy_q[32] ? -dy_q : dy_q;
    hx     = abs_dx[32:1];
    hy     = abs_dy[32:1];
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_P0:        begin mul_a = 33'(qx_q); mul_b = 33'(qy_q); end
      S_P1:        begin mul_a = 33'(qw_q); mul_b = 33'(qz_q); end
      S_P2:        begin mul_a = 33'(qw_q); mul_b = 33'(qw_q); end
      S_P3:        begin mul_a = 33'(qx_q); mul_b = 33'(qx_q); end
      S_P4:        begin mul_a = 33'(qy_q); mul_b = 33'(qy_q); end
      S_P5:        begin mul_a = 33'(qz_q); mul_b = 33'(qz_q); end
      S_T1:        begin mul_a = {1'b0, hx}; mul_b = {1'b0, hx}; end
      S_T2:        begin mul_a = {1'b0, hy}; mul_b = {1'b0, hy}; end
      S_NUM0:      begin mul_a = {13'd0, wb_q}; mul_b = 33'(c_q); end
      S_G0, S_G1:  begin mul_a = 33'(st_q); mul_b = {17'd0, gain_q}; end
      default:     begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // CORDIC request select
  always_comb begin
    c_req  = '0;
    c_x    = '0;
    c_y    = '0;
    c_z    = '0;
    fold_neg = 1'b0;
    a_fold = a_q;
    if (a_q > HALF_PI_Q13) begin
      a_fold   = a_q - PI_Q13;
      fold_neg = 1'b1;
    end else if (a_q < -HALF_PI_Q13) begin
      a_fold   = a_q + PI_Q13;
      fold_neg = 1'b1;
    end
    case (state_q)
      S_YAW_S: begin c_req.start = 1'b1; c_x = den_q; c_y = num_q <<< 1; end
      S_BRG_S: begin c_req.start = 1'b1; c_x = CW'(dx_q); c_y = CW'(dy_q); end
      S_COS_S: begin
        c_req.start = 1'b1;
        c_req.rot   = 1'b1;
        c_x         = COS_START;
        c_z         = AW'(a_fold) <<< 3;
      end
      S_ST_S:  begin c_req.start = 1'b1; c_x = den_q; c_y = num_q; end
      default: c_req = '0;
    endcase
  end

  assign sq_start = (state_q == S_SQ_S);

  // Angle and result shaping
  always_comb begin
    ang = round3(c_zo);
    yaw = 17'(ang) - 17'(HALF_PI_Q13);
    if (18'(yaw) < -PI_Q13) yaw = yaw + 17'(TWO_PI_Q13);

    a_sum = 18'(heading_q) + 18'(bearing_q);
    a_red = a_sum;
    if (a_sum > PI_Q13)       a_red = a_sum - TWO_PI_Q13;
    else if (a_sum < -PI_Q13) a_red = a_sum + TWO_PI_Q13;

    cos_r = round16(c_xo);
    cos_c = cos_r;
    if (cos_r > COS_MAX)       cos_c = COS_MAX;
    else if (cos_r < -COS_MAX) cos_c = -COS_MAX;
    if (neg_q) cos_c = -cos_c;

    gain_r = round14(prod_q[33:0]);
    if (gain_r > 34'sd32767)       steer_sat = 16'h7FFF;
    else if (gain_r < -34'sd32768) steer_sat = 16'h8000;
    else                           steer_sat = gain_r[15:0];
  end

  pps_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (c_req),
    .x_i    (c_x),
    .y_i    (c_y),
    .z_i    (c_z),
    .done_o (c_done),
    .x_o    (c_xo),
    .z_o    (c_zo)
  );

  pps_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .v_i     (sq_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // Sequencer, state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wb_q        <= WHEELBASE_RST;
      gain_q      <= GAIN_RST;
      car_x_q     <= '0;
      car_y_q     <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      heading_q   <= '0;
      pose_seen_q <= 1'b0;
      qw_q        <= '0;
      qx_q        <= '0;
      qy_q        <= '0;
      qz_q        <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      num_q       <= '0;
      den_q       <= '0;
      sq_q        <= '0;
      dist_q      <= '0;
      bearing_q   <= '0;
      c_q         <= '0;
      st_q        <= '0;
      a_q         <= '0;
      neg_q       <= 1'b0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      prod_q <= mul_full[63:0];

      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_WHEELBASE: wb_q   <= cfg_data_i;
          REG_GAIN:      gain_q <= cfg_data_i[15:0];
          default:       wb_q   <= wb_q;
        endcase
      end

      // load a new result, or drop the result once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= steer_sat;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            dx_q <= 33'(tgt_x_q) - 33'(car_x_q);
            dy_q <= 33'(tgt_y_q) - 33'(car_y_q);
            case (s_axis_tuser)
              OP_POSE: begin
                car_x_q <= s_axis_tdata[31:0];
                car_y_q <= s_axis_tdata[63:32];
                qw_q    <= s_axis_tdata[79:64];
                qx_q    <= s_axis_tdata[95:80];
                qy_q    <= s_axis_tdata[111:96];
                qz_q    <= s_axis_tdata[127:112];
                state_q <= S_P0;
              end
              OP_POINT: begin
                tgt_x_q <= s_axis_tdata[31:0];
                tgt_y_q <= s_axis_tdata[63:32];
              end
              OP_TICK: begin
                if (pose_seen_q) state_q <= S_T1;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        // quaternion yaw terms through the multiplier
        S_P0: state_q <= S_P1;
        S_P1: begin num_q <= CW'(prod_q); state_q <= S_P2; end
        S_P2: begin num_q <= num_q + CW'(prod_q); state_q <= S_P3; end
        S_P3: begin den_q <= CW'(prod_q); state_q <= S_P4; end
        S_P4: begin den_q <= den_q + CW'(prod_q); state_q <= S_P5; end
        S_P5: begin den_q <= den_q - CW'(prod_q); state_q <= S_P6; end
        S_P6: begin den_q <= den_q - CW'(prod_q); state_q <= S_YAW_S; end
        S_YAW_S: state_q <= S_YAW_W;
        S_YAW_W: begin
          if (c_done) begin
            heading_q   <= 16'(-yaw);
            pose_seen_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        // squared distance
        S_T1: state_q <= S_T2;
        S_T2: begin sq_q <= 64'(prod_q); state_q <= S_T3; end
        S_T3: begin sq_q <= sq_q + 64'(prod_q); state_q <= S_SQ_S; end
        S_SQ_S: state_q <= S_SQ_W;
        S_SQ_W: begin
          if (sq_done) begin
            dist_q  <= sq_root;
            state_q <= S_BRG_S;
          end
        end
        S_BRG_S: state_q <= S_BRG_W;
        S_BRG_W: begin
          if (c_done) begin
            bearing_q <= ang;
            state_q   <= S_RED;
          end
        end
        S_RED: begin a_q <= a_red; state_q <= S_COS_S; end
        S_COS_S: begin neg_q <= fold_neg; state_q <= S_COS_W; end
        S_COS_W: begin
          if (c_done) begin
            c_q     <= cos_c[15:0];
            state_q <= S_NUM0;
          end
        end
        S_NUM0: state_q <= S_NUM1;
        S_NUM1: begin
          num_q   <= CW'(prod_q) <<< 1;
          den_q   <= CW'({dist_q, 15'd0});
          state_q <= S_ST_S;
        end
        S_ST_S: state_q <= S_ST_W;
        S_ST_W: begin
          if (c_done) begin
            st_q    <= ang;
            state_q <= S_G0;
          end
        end
        S_G0: state_q <= S_G1;
        S_G1: begin
          // hold until the output register is free
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`include "pure_pursuit_steering_top_assert.svh"

  `PPS_ASSERT_NEXT(a_tick_busy, in_fire && s_axis_tuser == OP_TICK && pose_seen_q, !s_axis_tready)
  `PPS_ASSERT_SAME(a_cordic_done_wait, c_done, cordic_wait)
  `PPS_ASSERT_SAME(a_sqrt_done_wait, sq_done, state_q == S_SQ_W)

endmodule

// ----- rtl/core/pps_cordic.sv -----
// ----------------------------------------------------------------------------
// pps_cordic
// Shared iterative CORDIC: vectoring (atan2) or rotation (cos), one step a cycle.
// ----------------------------------------------------------------------------
module pps_cordic import pps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cordic_req_t          req_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [AW-1:0] z_i,
  output logic                 done_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [AW-1:0] z_o
);

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_PRE, C_ITER} cstate_e;

  cstate_e              state_q;
  logic signed [CW-1:0] x_q, y_q;
  logic signed [AW-1:0] z_q;
  logic [3:0]           cnt_q;
  logic                 rot_q;
  logic                 done_q;

  logic signed [CW-1:0] xs, ys;
  logic                 sig_pos;
  logic                 both_small;

  // Shifted terms, step direction and normalization test
  always_comb begin
    xs         = x_q >>> cnt_q;
    ys         = y_q >>> cnt_q;
    sig_pos    = rot_q ? (z_q >= 0) : !(y_q > 0);
    both_small = (x_q < NORM_LIM) && (x_q > -NORM_LIM) &&
                 (y_q < NORM_LIM) && (y_q > -NORM_LIM);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      cnt_q   <= '0;
      rot_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (req_i.start) begin
            rot_q <= req_i.rot;
            x_q   <= x_i;
            y_q   <= y_i;
            cnt_q <= '0;
            if (req_i.rot) begin
              z_q     <= z_i;
              state_q <= C_ITER;
            end else begin
              z_q <= '0;
              // atan2 of the origin is zero
              if (x_i == '0 && y_i == '0) done_q <= 1'b1;
              else                        state_q <= C_NORM;
            end
          end
        end
        C_NORM: begin
          if (both_small) begin
            x_q <= x_q <<< 1;
            y_q <= y_q <<< 1;
          end else begin
            state_q <= C_PRE;
          end
        end
        C_PRE: begin
          // bring the left half plane into the right one
          if (x_q < 0) begin
            if (y_q >= 0) begin
              x_q <= y_q;
              y_q <= -x_q;
              z_q <= HALF_PI_INT;
            end else begin
              x_q <= -y_q;
              y_q <= x_q;
              z_q <= -HALF_PI_INT;
            end
          end
          state_q <= C_ITER;
        end
        C_ITER: begin
          if (sig_pos) begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - atan_entry(cnt_q);
          end else begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + atan_entry(cnt_q);
          end
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'(CORDIC_STEPS - 1)) begin
            state_q <= C_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign z_o    = z_q;

endmodule

// ----- rtl/core/pps_isqrt.sv -----
// ----------------------------------------------------------------------------
// pps_isqrt
// Floor square root of a 64-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
module pps_isqrt import pps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] v_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, done_q;
  logic [63:0] v_q, r_q, bit_q;
  logic [4:0]  cnt_q;
  logic [63:0] trial;

  assign trial = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      v_q    <= '0;
      r_q    <= '0;
      bit_q  <= '0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        v_q    <= v_i;
        r_q    <= '0;
        bit_q  <= 64'h4000_0000_0000_0000;
        cnt_q  <= '0;
      end else if (busy_q) begin
        // restoring step: keep the bit if the remainder allows it
        if (v_q >= trial) begin
          v_q <= v_q - trial;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule
